// ===== src/sbr_pkg.sv =====
// ----------------------------------------------------------------------------
// Stereo bus router package
// Shared widths, register codes, item types, limiter constants and the
// tanh table used by the router and the limiter lanes.
// ----------------------------------------------------------------------------
package sbr_pkg;

   // Block dimensions
   localparam int BUS_COUNT        = 4;
   localparam int CHAN_COUNT       = 8;
   localparam int NUM_BUSES_DEF    = 4;
   localparam int MAX_CHANNELS_DEF = 8;

   // Field widths
   localparam int SAMPLE_W  = 24;
   localparam int SUM_W     = 26;
   localparam int OUT_W     = 24;
   localparam int CFG_W     = 4;
   localparam int CSR_IDX_W = 3;
   localparam int BUS_IDX_W = 2;

   // Limiter pipeline depth and latency from accept to result strobe
   localparam int LANE_STAGES = 5;
   localparam int PIPE_DEPTH  = LANE_STAGES + 1;
   localparam int LATENCY     = LANE_STAGES + 2;

   // Limiter constants
   localparam int THR20    = 1036013;
   localparam int THR23    = 8288105;
   localparam int KNEE20   = 12478;
   localparam int KNEE23   = 99824;
   localparam int TAB_LAST = 25;
   localparam int HALF16   = 32768;

   // Internal widths of the limiter lane
   localparam int E_W         = 17;
   localparam int U_W         = 19;
   localparam int IDX_W       = 5;
   localparam int FRAC_W      = 14;
   localparam int DIFF_W      = 14;
   localparam int T_W         = 17;
   localparam int P_W         = 33;
   localparam int RECIP_W     = 33;
   localparam int RECIP_SHIFT = 46;
   localparam int U_SHIFT     = RECIP_SHIFT - 16;

   // Excess at which the table index reaches its last entry
   localparam longint E_SAT = (longint'(TAB_LAST) * 16384 * KNEE20 + 65535) / 65536;
   localparam longint SAT_MAG = longint'(THR20) + E_SAT;
   // Rounded-up reciprocal of the knee, exact for every excess below E_SAT
   localparam longint RECIP = ((longint'(1) <<< RECIP_SHIFT) + KNEE20 - 1) / KNEE20;
   localparam logic [T_W-1:0] T_ONE = T_W'(65536);

   // tanh at quarter steps in Q.16, padded with the saturated value
   localparam logic [T_W-1:0] TANH_TAB [32] = '{
      17'd0,     17'd16051, 17'd30285, 17'd41625, 17'd49912, 17'd55593,
      17'd59320, 17'd61694, 17'd63179, 17'd64096, 17'd64659, 17'd65000,
      17'd65212, 17'd65339, 17'd65417, 17'd65464, 17'd65492, 17'd65509,
      17'd65520, 17'd65526, 17'd65530, 17'd65532, 17'd65534, 17'd65535,
      17'd65535, 17'd65536, 17'd65536, 17'd65536, 17'd65536, 17'd65536,
      17'd65536, 17'd65536
   };

   // Configuration register codes
   typedef enum logic [CSR_IDX_W-1:0] {
      REG_BUS0   = 3'd0,
      REG_BUS1   = 3'd1,
      REG_BUS2   = 3'd2,
      REG_BUS3   = 3'd3,
      REG_MUTE   = 3'd4,
      REG_ACTIVE = 3'd5
   } csr_reg_type;

   typedef struct packed {
      logic [BUS_COUNT-1:0][CFG_W-1:0] bus_chan;
      logic [CFG_W-1:0]                mute;
      logic [CFG_W-1:0]                active;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      bus_chan: {BUS_COUNT{4'hF}},
      mute:     4'h0,
      active:   4'd8
   };

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] bus0_left;
      logic signed [SAMPLE_W-1:0] bus0_right;
      logic signed [SAMPLE_W-1:0] bus1_left;
      logic signed [SAMPLE_W-1:0] bus1_right;
      logic signed [SAMPLE_W-1:0] bus2_left;
      logic signed [SAMPLE_W-1:0] bus2_right;
      logic signed [SAMPLE_W-1:0] bus3_left;
      logic signed [SAMPLE_W-1:0] bus3_right;
      logic                       frame_last;
   } req_type;

   typedef struct packed {
      logic signed [OUT_W-1:0] chan0_out;
      logic signed [OUT_W-1:0] chan1_out;
      logic signed [OUT_W-1:0] chan2_out;
      logic signed [OUT_W-1:0] chan3_out;
      logic signed [OUT_W-1:0] chan4_out;
      logic signed [OUT_W-1:0] chan5_out;
      logic signed [OUT_W-1:0] chan6_out;
      logic signed [OUT_W-1:0] chan7_out;
      logic                    block_end;
   } rsp_type;

   // Slope between neighboring table entries
   function automatic logic [DIFF_W-1:0] tanh_step(input logic [IDX_W-1:0] idx);
      logic [T_W-1:0] nxt;
      if (idx >= IDX_W'(TAB_LAST)) begin
         nxt = TANH_TAB[idx];
      end else begin
         nxt = TANH_TAB[idx + IDX_W'(1)];
      end
      return DIFF_W'(nxt - TANH_TAB[idx]);
   endfunction

endpackage

// ===== src/sbr_router.sv =====
// ----------------------------------------------------------------------------
// Bus router
// Routes each unmuted bus pair onto its device channels and registers the
// per-channel sums.
// ----------------------------------------------------------------------------
module sbr_router #(
   parameter int NUM_BUSES    = sbr_pkg::NUM_BUSES_DEF,
   parameter int MAX_CHANNELS = sbr_pkg::MAX_CHANNELS_DEF
) (
   input  logic                                clock,
   input  sbr_pkg::cfg_type                    cfg_i,
   input  sbr_pkg::req_type                    req_i,
   output logic signed [sbr_pkg::SUM_W-1:0]    sum_o [sbr_pkg::CHAN_COUNT]
);

   logic signed [sbr_pkg::SAMPLE_W-1:0] left_w  [sbr_pkg::BUS_COUNT];
   logic signed [sbr_pkg::SAMPLE_W-1:0] right_w [sbr_pkg::BUS_COUNT];
   logic signed [sbr_pkg::SUM_W-1:0]    sum_in  [sbr_pkg::CHAN_COUNT];
   logic signed [sbr_pkg::SUM_W-1:0]    sum_ff  [sbr_pkg::CHAN_COUNT];
   logic [sbr_pkg::CFG_W-1:0]           act_w;

   always_comb begin
      left_w[0]  = req_i.bus0_left;
      right_w[0] = req_i.bus0_right;
      left_w[1]  = req_i.bus1_left;
      right_w[1] = req_i.bus1_right;
      left_w[2]  = req_i.bus2_left;
      right_w[2] = req_i.bus2_right;
      left_w[3]  = req_i.bus3_left;
      right_w[3] = req_i.bus3_right;
   end

   // clamp the active count to the channels that exist
   assign act_w = (cfg_i.active > sbr_pkg::CFG_W'(MAX_CHANNELS)) ?
                  sbr_pkg::CFG_W'(MAX_CHANNELS) : cfg_i.active;

   always_comb begin
      for (int c = 0; c < sbr_pkg::CHAN_COUNT; c++) begin
         sum_in[c] = '0;
         for (int b = 0; b < sbr_pkg::BUS_COUNT; b++) begin
            if (b < NUM_BUSES && c < MAX_CHANNELS && !cfg_i.mute[b] &&
                !cfg_i.bus_chan[b][sbr_pkg::CFG_W-1] &&
                sbr_pkg::CFG_W'(c) < act_w) begin
               if ({1'b0, cfg_i.bus_chan[b][sbr_pkg::CFG_W-2:0]} ==
                   sbr_pkg::CFG_W'(c)) begin
                  sum_in[c] = sum_in[c] + sbr_pkg::SUM_W'(left_w[b]);
               end else if (({1'b0, cfg_i.bus_chan[b][sbr_pkg::CFG_W-2:0]} +
                             sbr_pkg::CFG_W'(1)) == sbr_pkg::CFG_W'(c)) begin
                  sum_in[c] = sum_in[c] + sbr_pkg::SUM_W'(right_w[b]);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      sum_ff <= sum_in;
   end

   assign sum_o = sum_ff;

endmodule

// ===== src/sbr_lane.sv =====
// ----------------------------------------------------------------------------
// Soft limiter lane
// Five-stage pipeline that passes one channel sum through the soft knee:
// excess, reciprocal scale, table lookup, interpolation, knee scale.
// ----------------------------------------------------------------------------
module sbr_lane (
   input  logic                              clock,
   input  logic signed [sbr_pkg::SUM_W-1:0]  sum_i,
   output logic signed [sbr_pkg::OUT_W-1:0]  y_o
);

   typedef struct packed {
      logic                            neg;
      logic                            lim;
      logic                            sat;
      logic signed [sbr_pkg::OUT_W-1:0] lin;
   } lane_ctl_type;

   lane_ctl_type                                     ctl_in;
   lane_ctl_type                                     ctl_ff [sbr_pkg::LANE_STAGES];
   logic [sbr_pkg::SUM_W-1:0]                        mag_w;
   logic [sbr_pkg::E_W-1:0]                          e_in, e_ff;
   logic [sbr_pkg::E_W+sbr_pkg::RECIP_W-1:0]         scale_w;
   logic [sbr_pkg::U_W-1:0]                          u_in, u_ff;
   logic [sbr_pkg::IDX_W-1:0]                        idx_w;
   logic [sbr_pkg::T_W-1:0]                          base_in, base_ff;
   logic [sbr_pkg::DIFF_W-1:0]                       diff_in, diff_ff;
   logic [sbr_pkg::FRAC_W-1:0]                       frac_in, frac_ff;
   logic [2*sbr_pkg::FRAC_W-1:0]                     interp_w;
   logic [sbr_pkg::T_W-1:0]                          t_in, t_ff;
   logic [sbr_pkg::P_W-1:0]                          p_in, p_ff;
   logic [sbr_pkg::P_W-1:0]                          rnd_w;
   logic [sbr_pkg::OUT_W-1:0]                        knee_mag_w;

   // excess over the threshold
   always_comb begin
      mag_w = sum_i[sbr_pkg::SUM_W-1] ? sbr_pkg::SUM_W'(-sum_i) : sbr_pkg::SUM_W'(sum_i);
      ctl_in.neg = sum_i[sbr_pkg::SUM_W-1];
      ctl_in.lim = mag_w > sbr_pkg::SUM_W'(sbr_pkg::THR20);
      ctl_in.sat = mag_w >= sbr_pkg::SUM_W'(sbr_pkg::SAT_MAG);
      ctl_in.lin = sbr_pkg::OUT_W'({sum_i[sbr_pkg::OUT_W-4:0], 3'b000});
      e_in = sbr_pkg::E_W'(mag_w - sbr_pkg::SUM_W'(sbr_pkg::THR20));
   end

   // excess over knee, Q.16
   always_comb begin
      scale_w = sbr_pkg::E_W'(e_ff) * (sbr_pkg::E_W + sbr_pkg::RECIP_W)'(sbr_pkg::RECIP);
      u_in    = scale_w[sbr_pkg::U_SHIFT +: sbr_pkg::U_W];
   end

   // table lookup
   always_comb begin
      idx_w   = u_ff[sbr_pkg::U_W-1 -: sbr_pkg::IDX_W];
      base_in = sbr_pkg::TANH_TAB[idx_w];
      diff_in = sbr_pkg::tanh_step(idx_w);
      frac_in = u_ff[sbr_pkg::FRAC_W-1:0];
   end

   // interpolate, saturate past the last entry
   always_comb begin
      interp_w = (2*sbr_pkg::FRAC_W)'(diff_ff) * (2*sbr_pkg::FRAC_W)'(frac_ff);
      t_in = ctl_ff[2].sat ? sbr_pkg::T_ONE :
             base_ff + sbr_pkg::T_W'(interp_w[2*sbr_pkg::FRAC_W-1:sbr_pkg::FRAC_W]);
   end

   // scale by the knee
   assign p_in = sbr_pkg::P_W'(t_ff) * sbr_pkg::P_W'(sbr_pkg::KNEE23);

   always_ff @(posedge clock) begin
      e_ff      <= e_in;
      u_ff      <= u_in;
      base_ff   <= base_in;
      diff_ff   <= diff_in;
      frac_ff   <= frac_in;
      t_ff      <= t_in;
      p_ff      <= p_in;
      ctl_ff[0] <= ctl_in;
      for (int k = 1; k < sbr_pkg::LANE_STAGES; k++) begin
         ctl_ff[k] <= ctl_ff[k-1];
      end
   end

   // round, add the threshold and restore the sign
   always_comb begin
      rnd_w      = p_ff + sbr_pkg::P_W'(sbr_pkg::HALF16);
      knee_mag_w = sbr_pkg::OUT_W'(sbr_pkg::THR23) +
                   sbr_pkg::OUT_W'(rnd_w[sbr_pkg::P_W-1:16]);
      if (!ctl_ff[sbr_pkg::LANE_STAGES-1].lim) begin
         y_o = ctl_ff[sbr_pkg::LANE_STAGES-1].lin;
      end else if (ctl_ff[sbr_pkg::LANE_STAGES-1].neg) begin
         y_o = -knee_mag_w;
      end else begin
         y_o = knee_mag_w;
      end
   end

endmodule

// ===== src/stereo_bus_router_soft_limiter.sv =====
// ----------------------------------------------------------------------------
// Stereo bus router with soft limiter
// Mixes four stereo buses onto up to eight device channels and limits each
// channel sum with a tanh soft knee.
// ----------------------------------------------------------------------------
// One frame is taken on every cycle that start is high; busy never rises, so
// frames may follow each other without gaps. Each frame gives one result on
// rsp_data, marked by a one-cycle rsp_valid pulse after the frame has passed
// one routing stage, five limiter stages and one merge register. The
// receiver cannot stall, so the result must be captured on
// that cycle. Each channel has its own limiter lane, so all channels are
// done in parallel and the throughput is one frame per clock. Write the
// channel, mute and active-count registers only while no frame is in flight;
// they apply to every frame taken afterwards. Channels at or above the active
// count read zero.
// ----------------------------------------------------------------------------
module stereo_bus_router_soft_limiter #(
   parameter int NUM_BUSES    = sbr_pkg::NUM_BUSES_DEF,
   parameter int MAX_CHANNELS = sbr_pkg::MAX_CHANNELS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   // frame input
   input  logic                          start,
   output logic                          busy,
   input  sbr_pkg::req_type              req_data,
   // result output
   output logic                          rsp_valid,
   output sbr_pkg::rsp_type              rsp_data,
   // register write port
   input  logic                          csr_we,
   input  logic [sbr_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [sbr_pkg::CFG_W-1:0]     csr_wdata
);

   sbr_pkg::cfg_type                     cfg_in, cfg_ff;
   logic                                 accept_w;
   logic [sbr_pkg::PIPE_DEPTH-1:0]       vld_in, vld_ff;
   logic [sbr_pkg::PIPE_DEPTH-1:0]       last_ff;
   logic signed [sbr_pkg::SUM_W-1:0]     sum_w  [sbr_pkg::CHAN_COUNT];
   logic signed [sbr_pkg::OUT_W-1:0]     lane_y [sbr_pkg::CHAN_COUNT];
   sbr_pkg::rsp_type                     rsp_in, rsp_ff;
   logic                                 rsp_valid_in, rsp_valid_ff;

   // The pipeline never stalls, so a frame is always welcome
   assign busy     = 1'b0;
   assign accept_w = start & ~busy;

   // Register writes: decode the index, drop writes beyond the list
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (sbr_pkg::csr_reg_type'(csr_index)) inside
            sbr_pkg::REG_BUS0, sbr_pkg::REG_BUS1,
            sbr_pkg::REG_BUS2, sbr_pkg::REG_BUS3: begin
               cfg_in.bus_chan[csr_index[sbr_pkg::BUS_IDX_W-1:0]] = csr_wdata;
            end
            sbr_pkg::REG_MUTE: begin
               cfg_in.mute = csr_wdata;
            end
            sbr_pkg::REG_ACTIVE: begin
               cfg_in.active = csr_wdata;
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= sbr_pkg::CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Route the buses and register the channel sums
   sbr_router #(
      .NUM_BUSES    (NUM_BUSES),
      .MAX_CHANNELS (MAX_CHANNELS)
   ) u_router (
      .clock (clock),
      .cfg_i (cfg_ff),
      .req_i (req_data),
      .sum_o (sum_w)
   );

   // One limiter lane per channel; channels beyond the build width read zero
   for (genvar c = 0; c < sbr_pkg::CHAN_COUNT; c++) begin : g_lane
      if (c < MAX_CHANNELS) begin : g_on
         sbr_lane u_lane (
            .clock (clock),
            .sum_i (sum_w[c]),
            .y_o   (lane_y[c])
         );
      end else begin : g_off
         assign lane_y[c] = '0;
      end
   end

   // Track frames through the routing and limiter stages
   assign vld_in = {vld_ff[sbr_pkg::PIPE_DEPTH-2:0], accept_w};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // end-of-block flag rides alongside the frame
   always_ff @(posedge clock) begin
      last_ff <= {last_ff[sbr_pkg::PIPE_DEPTH-2:0], req_data.frame_last};
   end

   // Merge the lane results into one result item and register it
   always_comb begin
      rsp_in.chan0_out = lane_y[0];
      rsp_in.chan1_out = lane_y[1];
      rsp_in.chan2_out = lane_y[2];
      rsp_in.chan3_out = lane_y[3];
      rsp_in.chan4_out = lane_y[4];
      rsp_in.chan5_out = lane_y[5];
      rsp_in.chan6_out = lane_y[6];
      rsp_in.chan7_out = lane_y[7];
      rsp_in.block_end = last_ff[sbr_pkg::PIPE_DEPTH-1];
      rsp_valid_in     = vld_ff[sbr_pkg::PIPE_DEPTH-1];
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef NO_ASSERTIONS
   // every accepted frame yields its result after the fixed latency
   a_latency : assert property (@(posedge clock) disable iff (reset)
      accept_w |-> ##(sbr_pkg::LATENCY) rsp_valid)
      else $error("result missing after frame accept");

   // no result without a frame taken the fixed latency earlier
   a_no_spurious : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept_w, sbr_pkg::LATENCY))
      else $error("result without a matching frame");

   // the limiter keeps the channel 0 output inside the knee ceiling
   a_ceiling : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($signed(rsp_data.chan0_out) <= 24'sd8387929 &&
                     $signed(rsp_data.chan0_out) >= -24'sd8387929))
      else $error("limited output beyond the knee ceiling");
`endif

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stereo bus router soft limiter testbench
// Drives audio frames through the router under a series of register settings
// and checks every limited channel sample against an independent predictor.
// ----------------------------------------------------------------------------
import sbr_pkg::*;

// Limiter constants: knee start and width in Q3.20, floor and width in Q0.23
localparam longint KNEE_START  = 1036013;
localparam longint KNEE_WIDTH  = 12478;
localparam longint LIM_FLOOR   = 8288105;
localparam longint LIM_SPAN    = 99824;
localparam int     TANH_POINTS = 25;
localparam int     SAT_EXCESS  = 77988;

// tanh at quarter steps, Q.16
localparam longint TANH_Q16 [26] = '{
   0, 16051, 30285, 41625, 49912, 55593, 59320, 61694,
   63179, 64096, 64659, 65000, 65212, 65339, 65417, 65464,
   65492, 65509, 65520, 65526, 65530, 65532, 65534, 65535,
   65535, 65536
};

// Register indexes that decode to nothing
localparam logic [CSR_IDX_W-1:0] REG_SPARE_A = 3'd6;
localparam logic [CSR_IDX_W-1:0] REG_SPARE_B = 3'd7;

class frame_scoreboard;
   logic [CFG_W-1:0] bus_chan [BUS_COUNT];
   logic [CFG_W-1:0] mute;
   logic [CFG_W-1:0] active;
   rsp_type          mix_q [$];
   int               frames_seen;
   int               results_checked;
   int               mismatches;
   int               knee_hits;

   function new();
      foreach (bus_chan[b]) bus_chan[b] = 4'hF;
      mute            = 4'h0;
      active          = 4'd8;
      frames_seen     = 0;
      results_checked = 0;
      mismatches      = 0;
      knee_hits       = 0;
   endfunction

   function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      case (idx)
         REG_BUS0:   bus_chan[0] = val;
         REG_BUS1:   bus_chan[1] = val;
         REG_BUS2:   bus_chan[2] = val;
         REG_BUS3:   bus_chan[3] = val;
         REG_MUTE:   mute = val;
         REG_ACTIVE: active = val;
         default:    ;
      endcase
   endfunction

   function int pending();
      return mix_q.size();
   endfunction

   function logic [OUT_W-1:0] soft_limit(longint x);
      longint mag, excess, u, idx, frac, slope, th, y;
      mag = (x < 0) ? -x : x;
      if (mag <= KNEE_START) return OUT_W'(x * 8);
      knee_hits++;
      excess = mag - KNEE_START;
      u      = (excess * 65536) / KNEE_WIDTH;
      idx    = u / 16384;
      frac   = u % 16384;
      if (idx >= TANH_POINTS) begin
         th = 65536;
      end else begin
         slope = TANH_Q16[idx + 1] - TANH_Q16[idx];
         th    = TANH_Q16[idx] + (slope * frac) / 16384;
      end
      y = LIM_FLOOR + (LIM_SPAN * th + 32768) / 65536;
      return (x < 0) ? OUT_W'(-y) : OUT_W'(y);
   endfunction

   function void note_frame(req_type f);
      logic signed [SAMPLE_W-1:0] left [BUS_COUNT];
      logic signed [SAMPLE_W-1:0] right [BUS_COUNT];
      longint                     sums [CHAN_COUNT];
      logic [OUT_W-1:0]           lane [CHAN_COUNT];
      int                         act, off;
      rsp_type                    mix;
      left[0] = f.bus0_left;  right[0] = f.bus0_right;
      left[1] = f.bus1_left;  right[1] = f.bus1_right;
      left[2] = f.bus2_left;  right[2] = f.bus2_right;
      left[3] = f.bus3_left;  right[3] = f.bus3_right;
      act = (active > 4'd8) ? 8 : int'(active);
      foreach (sums[c]) sums[c] = 0;
      for (int b = 0; b < BUS_COUNT; b++) begin
         off = int'($signed(bus_chan[b]));
         if (!mute[b] && off >= 0) begin
            if (off < act) sums[off] += left[b];
            if (off + 1 < act) sums[off + 1] += right[b];
         end
      end
      foreach (lane[c]) lane[c] = (c < act) ? soft_limit(sums[c]) : '0;
      mix.chan0_out = lane[0];
      mix.chan1_out = lane[1];
      mix.chan2_out = lane[2];
      mix.chan3_out = lane[3];
      mix.chan4_out = lane[4];
      mix.chan5_out = lane[5];
      mix.chan6_out = lane[6];
      mix.chan7_out = lane[7];
      mix.block_end = f.frame_last;
      mix_q = {mix_q, mix};
      frames_seen++;
   endfunction

   function logic [OUT_W-1:0] chan_of(rsp_type r, int c);
      case (c)
         0:       return r.chan0_out;
         1:       return r.chan1_out;
         2:       return r.chan2_out;
         3:       return r.chan3_out;
         4:       return r.chan4_out;
         5:       return r.chan5_out;
         6:       return r.chan6_out;
         default: return r.chan7_out;
      endcase
   endfunction

   function void check_result(rsp_type got);
      rsp_type want;
      if (mix_q.size() == 0) begin
         mismatches++;
         $display("%0t: result with no frame pending: expected none, got %h", $time, got);
         return;
      end
      want = mix_q.pop_front();
      results_checked++;
      for (int c = 0; c < CHAN_COUNT; c++) begin
         if (chan_of(got, c) !== chan_of(want, c)) begin
            mismatches++;
            $display("%0t: chan%0d_out expected %h got %h",
                     $time, c, chan_of(want, c), chan_of(got, c));
         end
      end
      if (got.block_end !== want.block_end) begin
         mismatches++;
         $display("%0t: block_end expected %b got %b", $time, want.block_end, got.block_end);
      end
   endfunction
endclass

module tb;
   localparam int STALL_LIMIT   = 2000;
   localparam int SETTLE_CYCLES = 12;
   localparam int RANDOM_PHASES = 16;

   logic                 clock;
   logic                 reset     = 1'b1;
   logic                 start     = 1'b0;
   logic                 busy;
   req_type              req_data  = '0;
   logic                 rsp_valid;
   rsp_type              rsp_data;
   logic                 csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CFG_W-1:0]     csr_wdata = '0;

   frame_scoreboard sb = new();
   int idle_cycles      = 0;
   int burst_left       = 0;
   int settings_applied = 0;

   stereo_bus_router_soft_limiter uut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Record each frame the block takes and check each result on its strobe cycle.
   always @(posedge clock) begin
      if (!reset && start && !busy) sb.note_frame(req_data);
      if (!reset && rsp_valid) sb.check_result(rsp_data);
   end

   // Count cycles in which neither side moves an item.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      while (idle_cycles < STALL_LIMIT) @(posedge clock);
      $display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
      $display("end of test: mismatches");
      $finish;
   end

   // Hold until every predicted result has come out; always wait for an edge
   // first so a frame taken on this edge is already on the books.
   task automatic drain();
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      sb.write_reg(idx, val);
   endtask

   // Stop the sender, let the pipe empty, then rewrite every register.
   task automatic apply_setting(input logic [CFG_W-1:0] c0, input logic [CFG_W-1:0] c1,
                                input logic [CFG_W-1:0] c2, input logic [CFG_W-1:0] c3,
                                input logic [CFG_W-1:0] mute, input logic [CFG_W-1:0] act,
                                input bit spare);
      start <= 1'b0;
      drain();
      write_reg(REG_BUS0, c0);
      write_reg(REG_BUS1, c1);
      write_reg(REG_BUS2, c2);
      write_reg(REG_BUS3, c3);
      write_reg(REG_MUTE, mute);
      write_reg(REG_ACTIVE, act);
      // Indexes past the last register must leave everything alone
      if (spare) begin
         write_reg(REG_SPARE_A, 4'($urandom));
         write_reg(REG_SPARE_B, 4'($urandom));
      end
      csr_we <= 1'b0;
      settings_applied++;
   endtask

   // Send one frame. The sender runs in bursts; between bursts it idles for a
   // random gap, and now and then holds off until the pipe is empty.
   task automatic send_frame(input req_type f);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 48);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clock);
            if ($urandom_range(0, 9) == 0) drain();
         end
      end
      burst_left--;
      req_data <= f;
      start    <= 1'b1;
      do @(posedge clock); while (busy);
   endtask

   function automatic req_type mk_frame(input longint l0, input longint r0,
                                        input longint l1, input longint r1,
                                        input longint l2, input longint r2,
                                        input longint l3, input longint r3,
                                        input bit last);
      req_type f;
      f.bus0_left  = SAMPLE_W'(l0);
      f.bus0_right = SAMPLE_W'(r0);
      f.bus1_left  = SAMPLE_W'(l1);
      f.bus1_right = SAMPLE_W'(r1);
      f.bus2_left  = SAMPLE_W'(l2);
      f.bus2_right = SAMPLE_W'(r2);
      f.bus3_left  = SAMPLE_W'(l3);
      f.bus3_right = SAMPLE_W'(r3);
      f.frame_last = last;
      return f;
   endfunction

   // Weight samples toward the knee: alone, or as halves and quarters that
   // land near it once two or four buses are summed onto one channel.
   function automatic longint pick_sample();
      longint mag;
      case ($urandom_range(0, 7))
         0, 1: return longint'($signed(SAMPLE_W'($urandom)));
         2:    mag = (KNEE_START >> $urandom_range(0, 2)) + $urandom_range(0, 8) - 4;
         3:    mag = KNEE_START + $urandom_range(0, SAT_EXCESS + 12000);
         4:    mag = (KNEE_START >> $urandom_range(1, 2)) + $urandom_range(0, 30000);
         5:    mag = $urandom_range(0, 1 << 20);
         6:    return ($urandom_range(0, 1) == 1) ? 8388607 : -8388608;
         default: mag = $urandom_range(0, 3);
      endcase
      return ($urandom_range(0, 1) == 1) ? -mag : mag;
   endfunction

   function automatic req_type rand_frame();
      return mk_frame(pick_sample(), pick_sample(), pick_sample(), pick_sample(),
                      pick_sample(), pick_sample(), pick_sample(), pick_sample(),
                      $urandom_range(0, 15) == 0);
   endfunction

   // Mostly plain routings; some with any 4-bit value, some at the corners.
   task automatic random_setting();
      logic [CFG_W-1:0] ch [BUS_COUNT];
      logic [CFG_W-1:0] mute, act;
      int               mode;
      mode = $urandom_range(0, 9);
      foreach (ch[b]) begin
         ch[b] = (mode < 6) ? 4'($urandom_range(0, 7)) : 4'($urandom);
         if ($urandom_range(0, 7) == 0) ch[b] = 4'hF;
      end
      mute = ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'h0;
      act  = (mode < 6) ? 4'($urandom_range(1, 8)) : 4'($urandom);
      if (mode == 9) begin
         case ($urandom_range(0, 3))
            0: act = 4'd0;
            1: act = 4'd15;
            2: act = 4'd1;
            default: act = 4'd8;
         endcase
      end
      apply_setting(ch[0], ch[1], ch[2], ch[3], mute, act, $urandom_range(0, 3) == 0);
   endtask

   initial begin
      int n;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Out of reset every bus is unassigned: all channels read zero
      send_frame(rand_frame());

      // One bus per channel pair: extremes, exact threshold, one past it,
      // saturation edge and points along the knee
      apply_setting(4'd0, 4'd2, 4'd4, 4'd6, 4'h0, 4'd8, 1'b0);
      send_frame(mk_frame(8388607, 8388607, -8388608, -8388608,
                          8388607, -8388608, -8388608, 8388607, 1'b1));
      send_frame(mk_frame(KNEE_START, -KNEE_START, KNEE_START + 1, -(KNEE_START + 1),
                          0, 1, -1, KNEE_START - 1, 1'b0));
      send_frame(mk_frame(KNEE_START + SAT_EXCESS, -(KNEE_START + SAT_EXCESS),
                          KNEE_START + SAT_EXCESS - 1, -(KNEE_START + SAT_EXCESS - 1),
                          KNEE_START + 6239, -(KNEE_START + 6239),
                          KNEE_START + 40000, -(KNEE_START + 77000), 1'b0));

      // All buses on one pair: left sum lands exactly on the threshold,
      // right sum just above it; then the widest sums either way
      apply_setting(4'd3, 4'd3, 4'd3, 4'd3, 4'h0, 4'd8, 1'b0);
      send_frame(mk_frame(259003, 259004, 259003, 259004,
                          259003, 259004, 259004, 259004, 1'b0));
      send_frame(mk_frame(8388607, 8388607, 8388607, 8388607,
                          8388607, 8388607, 8388607, 8388607, 1'b1));
      send_frame(mk_frame(-8388608, -8388608, -8388608, -8388608,
                          -8388608, -8388608, -8388608, -8388608, 1'b0));

      // Right sample past the last channel, unassigned and negative offsets,
      // active count above the channel count
      apply_setting(4'd7, 4'd0, 4'hF, 4'h8, 4'h0, 4'd15, 1'b0);
      send_frame(rand_frame());
      send_frame(rand_frame());

      // Muted bus, bus wholly past the active count, right past it
      apply_setting(4'd0, 4'd1, 4'd5, 4'd4, 4'b0010, 4'd5, 1'b0);
      send_frame(rand_frame());
      send_frame(rand_frame());

      // Single active channel with two left samples summed on it
      apply_setting(4'd0, 4'd0, 4'd1, 4'd6, 4'h0, 4'd1, 1'b0);
      send_frame(rand_frame());

      // No active channel: only the block end marker passes
      apply_setting(4'd0, 4'd2, 4'd4, 4'd6, 4'h0, 4'd0, 1'b0);
      send_frame(mk_frame(8388607, 1, 2, 3, 4, 5, 6, 7, 1'b1));

      // Writes to undecoded indexes must be dropped
      apply_setting(4'd0, 4'd2, 4'd4, 4'd6, 4'h0, 4'd8, 1'b1);
      send_frame(rand_frame());

      // Every bus muted
      apply_setting(4'd0, 4'd2, 4'd4, 4'd6, 4'hF, 4'd8, 1'b0);
      send_frame(rand_frame());

      // Random phases, each under a fresh register setting
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         random_setting();
         n = $urandom_range(30, 70);
         for (int k = 0; k < n; k++) begin
            // Halfway through one phase, hold off until the pipe drains
            if (phase == RANDOM_PHASES / 2 && k == n / 2) begin
               start <= 1'b0;
               drain();
            end
            send_frame(rand_frame());
         end
      end

      start <= 1'b0;
      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("%0d frames checked across %0d register settings, %0d results compared",
               sb.frames_seen, settings_applied, sb.results_checked);
      $display("%0d channel sums went past the limiter threshold", sb.knee_hits);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end
endmodule
